// ===== hw/rtl/tcke_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcke_pkg
// Shared constants, codes and helpers for the text console key engine.
// ----------------------------------------------------------------------------
package tcke_pkg;

   // Geometry
   localparam int CELLS        = 16384;
   localparam int LINE_WIDTH   = 80;
   localparam int SCREEN_CELLS = 80 * 25;
   localparam int TAB_STOP     = 4;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int WIDE_W = ADDR_W + 2;
   localparam int CNT_W  = $clog2(LINE_WIDTH + 2);

   // Division by a constant through a scaled reciprocal
   localparam int DIV_SHIFT  = 22;
   localparam int RECIP_W    = 23;
   localparam int LINE_RECIP = ((2 ** DIV_SHIFT) + LINE_WIDTH - 1) / LINE_WIDTH;
   localparam int TAB_RECIP  = ((2 ** DIV_SHIFT) + TAB_STOP - 1) / TAB_STOP;

   // Reset values of the color registers
   localparam logic [7:0] RESET_DEFAULT_COLOR   = 8'h07;
   localparam logic [7:0] RESET_HIGHLIGHT_COLOR = 8'h09;

   // Characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] MARKER_COLOR = 8'h00;

   // Request types
   localparam logic [1:0] REQ_KEY   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Key classes
   localparam logic [2:0] KEY_CHAR     = 3'd0;
   localparam logic [2:0] KEY_ENTER    = 3'd1;
   localparam logic [2:0] KEY_BACK     = 3'd2;
   localparam logic [2:0] KEY_TAB      = 3'd3;
   localparam logic [2:0] KEY_ESC      = 3'd4;
   localparam logic [2:0] KEY_PAGEUP   = 3'd5;
   localparam logic [2:0] KEY_PAGEDOWN = 3'd6;

   // Console modes
   localparam logic [1:0] MODE_TYPING  = 2'd0;
   localparam logic [1:0] MODE_PATTERN = 2'd1;
   localparam logic [1:0] MODE_HILITE  = 2'd2;

   // Register indexes
   localparam logic CSR_DEFAULT_COLOR   = 1'b0;
   localparam logic CSR_HIGHLIGHT_COLOR = 1'b1;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIV,
      ST_EMIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FOLLOW,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_HL_WR,
      ST_RS_BLANK,
      ST_RS_RD,
      ST_RS_CHK,
      ST_SWEEP,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_CHAR,
      ACT_EMIT,
      ACT_SEARCH,
      ACT_PATTERN,
      ACT_RESTORE,
      ACT_UP,
      ACT_DOWN,
      ACT_CLEAR,
      ACT_READ
   } action_type;

   typedef enum logic [1:0] {
      OP_TAB,
      OP_NL,
      OP_BS
   } emit_op_type;

   // Clamp a cell index to the last cell
   function automatic logic [ADDR_W-1:0] sat_cell(input logic [WIDE_W-1:0] v);
      logic [ADDR_W-1:0] r;
      if (v > WIDE_W'(CELLS - 1)) begin
         r = ADDR_W'(CELLS - 1);
      end else begin
         r = v[ADDR_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/text_console_key_engine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_key_engine_top
// Text console: cell memory, cursor, view and pattern search, run by one
// sequencer over a dual-read cell memory, one memory step per cycle.
// Paging, ignored and pattern-start keys go straight to the result, reads via a
//   registered read, characters via view-follow, markers via divide, emit and
//   view-follow, backspace also via a marker scan. Search: read and check per
//   compare step, a write per highlighted cell. Restore: a write per blanked
//   cell, a read and check per cell up to the base. One transaction at a time;
//   the next is taken in the cycle after the result is registered, and a stalled
//   result holds the sequencer. Reset first clears all CELLS (16384) cells.
// ----------------------------------------------------------------------------
module text_console_key_engine_top
   import tcke_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [2:0]  req_key_class,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [13:0] req_read_addr,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [13:0]      rsp_cursor_cell,
   output logic [13:0]      rsp_view_first_cell,
   output logic [1:0]       rsp_console_mode,
   output logic [7:0]       rsp_cell_char,
   output logic [7:0]       rsp_cell_color,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [ADDR_W-1:0] view_ff, view_in;
   logic [1:0]        mode_ff, mode_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [7:0]        dflt_ff, dflt_in;
   logic [7:0]        hl_ff, hl_in;
   logic [7:0]        sweep_color_ff, sweep_color_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [WIDE_W-1:0] start_ff, start_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic [ADDR_W-1:0] q_line_ff, q_line_in;
   logic [ADDR_W-1:0] q_tab_ff, q_tab_in;
   emit_op_type       op_ff, op_in;
   logic              scan_nl_ff, scan_nl_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [7:0]        cell_char_ff, cell_char_in;
   logic [7:0]        cell_color_ff, cell_color_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [ADDR_W-1:0] rsp_view_ff, rsp_view_in;
   logic [1:0]        rsp_mode_ff, rsp_mode_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [7:0]        rsp_color_ff, rsp_color_in;

   // Cell memory
   logic [7:0]        glyph_mem [CELLS];
   logic [7:0]        attr_mem [CELLS];
   logic              glyph_we, attr_we;
   logic [ADDR_W-1:0] wr_addr, rd_a, rd_b;
   logic [7:0]        wr_glyph, wr_attr;
   logic [7:0]        glyph_a_ff, glyph_b_ff, attr_a_ff;

   // Decoded request
   action_type  act;
   emit_op_type act_op;
   logic        req_acc;
   logic        rsp_free;

   // Shared arithmetic
   logic [ADDR_W+RECIP_W-1:0] prod_line, prod_tab;
   logic [WIDE_W-1:0] view_sum, line_start, line_next, tab_start, tab_next;
   logic [WIDE_W-1:0] seg_end;
   logic              follow_go, at_line, at_tab, scan_go, cmp_fit;
   logic [CNT_W-1:0]  scan_limit;
   logic [7:0]        scan_marker;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign prod_line  = {{RECIP_W{1'b0}}, cursor_ff} * (ADDR_W + RECIP_W)'(LINE_RECIP);
   assign prod_tab   = {{RECIP_W{1'b0}}, cursor_ff} * (ADDR_W + RECIP_W)'(TAB_RECIP);
   assign view_sum   = WIDE_W'(view_ff) + WIDE_W'(SCREEN_CELLS);
   assign line_start = WIDE_W'(q_line_ff) * WIDE_W'(LINE_WIDTH);
   assign line_next  = (WIDE_W'(q_line_ff) + WIDE_W'(1)) * WIDE_W'(LINE_WIDTH);
   assign tab_start  = WIDE_W'(q_tab_ff) * WIDE_W'(TAB_STOP);
   assign tab_next   = (WIDE_W'(q_tab_ff) + WIDE_W'(1)) * WIDE_W'(TAB_STOP);
   assign seg_end    = start_ff + WIDE_W'(len_ff) - WIDE_W'(1);
   assign follow_go  = (WIDE_W'(cursor_ff) >= view_sum) && (view_sum < WIDE_W'(CELLS));
   assign at_line    = (WIDE_W'(cursor_ff) == line_start);
   assign at_tab     = (WIDE_W'(cursor_ff) == tab_start);
   assign scan_limit = scan_nl_ff ? CNT_W'(LINE_WIDTH) : CNT_W'(TAB_STOP);
   assign scan_marker = scan_nl_ff ? CH_NL : CH_TAB;
   assign scan_go    = (ptr_ff != '0) && (cnt_ff <= scan_limit);
   assign cmp_fit    = (start_ff + WIDE_W'(len_ff)) <= WIDE_W'(base_ff);

   // Decode the request into one action
   always_comb begin
      act    = ACT_NONE;
      act_op = OP_BS;
      unique case (req_type)
         REQ_KEY: begin
            if (mode_ff == MODE_HILITE) begin
               if (req_key_class == KEY_ESC) act = ACT_RESTORE;
            end else begin
               case (req_key_class)
                  KEY_CHAR: begin
                     if (req_char_code == CH_TAB) begin
                        act = ACT_EMIT; act_op = OP_TAB;
                     end else if (req_char_code == CH_NL) begin
                        act = ACT_EMIT; act_op = OP_NL;
                     end else if (req_char_code == CH_BS) begin
                        act = ACT_EMIT; act_op = OP_BS;
                     end else begin
                        act = ACT_CHAR;
                     end
                  end
                  KEY_ENTER: begin
                     if (mode_ff == MODE_PATTERN) begin
                        act = ACT_SEARCH;
                     end else begin
                        act = ACT_EMIT; act_op = OP_NL;
                     end
                  end
                  KEY_BACK: begin
                     act = ACT_EMIT; act_op = OP_BS;
                  end
                  KEY_TAB: begin
                     act = ACT_EMIT; act_op = OP_TAB;
                  end
                  KEY_ESC: begin
                     if (mode_ff == MODE_TYPING) act = ACT_PATTERN;
                  end
                  KEY_PAGEUP:   act = ACT_UP;
                  KEY_PAGEDOWN: act = ACT_DOWN;
                  default:      act = ACT_NONE;
               endcase
            end
         end
         REQ_CLEAR: begin
            if (mode_ff == MODE_TYPING) act = ACT_CLEAR;
         end
         REQ_READ: act = ACT_READ;
         default:  act = ACT_NONE;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (ptr_ff == ADDR_W'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               unique case (act)
                  ACT_CHAR:    state_in = ST_FOLLOW;
                  ACT_EMIT:    state_in = ST_DIV;
                  ACT_SEARCH:  state_in = (cursor_ff <= base_ff) ? ST_FINISH : ST_CMP_RD;
                  ACT_RESTORE: state_in = (cursor_ff >= base_ff) ? ST_RS_BLANK : ST_RS_RD;
                  ACT_CLEAR:   state_in = ST_SWEEP;
                  ACT_READ:    state_in = ST_READ;
                  default:     state_in = ST_FINISH;
               endcase
            end
         end
         ST_DIV: state_in = ST_EMIT;
         ST_EMIT: begin
            if (op_ff == OP_BS && (at_line || at_tab)) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_FOLLOW;
            end
         end
         ST_SCAN_RD: begin
            if (scan_go) begin
               state_in = ST_SCAN_CHK;
            end else if (!(scan_nl_ff && at_tab)) begin
               state_in = ST_FOLLOW;
            end
         end
         ST_SCAN_CHK: begin
            state_in = (glyph_a_ff == scan_marker) ? ST_FOLLOW : ST_SCAN_RD;
         end
         ST_FOLLOW: begin
            if (!follow_go) state_in = ST_FINISH;
         end
         ST_CMP_RD: state_in = cmp_fit ? ST_CMP_CHK : ST_FINISH;
         ST_CMP_CHK: begin
            if (glyph_a_ff != glyph_b_ff) begin
               state_in = ST_CMP_RD;
            end else if (idx_ff == len_ff - ADDR_W'(1)) begin
               state_in = ST_HL_WR;
            end else begin
               state_in = ST_CMP_RD;
            end
         end
         ST_HL_WR: begin
            if (WIDE_W'(ptr_ff) == seg_end) state_in = ST_CMP_RD;
         end
         ST_RS_BLANK: begin
            if (ptr_ff == cursor_ff) state_in = ST_RS_RD;
         end
         ST_RS_RD: state_in = ST_RS_CHK;
         ST_RS_CHK: state_in = (ptr_ff == base_ff) ? ST_FINISH : ST_RS_RD;
         ST_SWEEP: begin
            if (ptr_ff == ADDR_W'(CELLS - 1)) state_in = ST_FINISH;
         end
         ST_READ: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      cursor_in      = cursor_ff;
      view_in        = view_ff;
      mode_in        = mode_ff;
      base_in        = base_ff;
      dflt_in        = dflt_ff;
      hl_in          = hl_ff;
      sweep_color_in = sweep_color_ff;
      ptr_in         = ptr_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      start_in       = start_ff;
      len_in         = len_ff;
      q_line_in      = q_line_ff;
      q_tab_in       = q_tab_ff;
      op_in          = op_ff;
      scan_nl_in     = scan_nl_ff;
      rd_ok_in       = rd_ok_ff;
      cell_char_in   = cell_char_ff;
      cell_color_in  = cell_color_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_cursor_in  = rsp_cursor_ff;
      rsp_view_in    = rsp_view_ff;
      rsp_mode_in    = rsp_mode_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_color_in   = rsp_color_ff;
      glyph_we       = 1'b0;
      attr_we        = 1'b0;
      wr_addr        = ptr_ff;
      wr_glyph       = CH_SPACE;
      wr_attr        = dflt_ff;
      rd_a           = ptr_ff;
      rd_b           = base_ff;

      // Take register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEFAULT_COLOR:   dflt_in = csr_wdata;
            CSR_HIGHLIGHT_COLOR: hl_in   = csr_wdata;
            default: ;
         endcase
      end

      // Drop the result once taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_INIT, ST_SWEEP: begin
            glyph_we = 1'b1;
            attr_we  = 1'b1;
            wr_attr  = sweep_color_ff;
            ptr_in   = ptr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_acc) begin
               cell_char_in  = '0;
               cell_color_in = '0;
               op_in         = act_op;
               unique case (act)
                  ACT_CHAR: begin
                     glyph_we  = 1'b1;
                     attr_we   = 1'b1;
                     wr_addr   = cursor_ff;
                     wr_glyph  = req_char_code;
                     wr_attr   = (mode_ff == MODE_PATTERN) ? hl_ff : dflt_ff;
                     cursor_in = sat_cell(WIDE_W'(cursor_ff) + WIDE_W'(1));
                  end
                  ACT_SEARCH: begin
                     mode_in  = MODE_HILITE;
                     len_in   = cursor_ff - base_ff;
                     start_in = '0;
                     idx_in   = '0;
                  end
                  ACT_PATTERN: begin
                     mode_in = MODE_PATTERN;
                     base_in = cursor_ff;
                  end
                  ACT_RESTORE: begin
                     ptr_in = (cursor_ff >= base_ff) ? base_ff : '0;
                  end
                  ACT_UP: begin
                     view_in = (view_ff >= ADDR_W'(LINE_WIDTH)) ?
                               view_ff - ADDR_W'(LINE_WIDTH) : '0;
                  end
                  ACT_DOWN: begin
                     if (view_sum < WIDE_W'(CELLS)) view_in = view_ff + ADDR_W'(LINE_WIDTH);
                  end
                  ACT_CLEAR: begin
                     cursor_in      = '0;
                     ptr_in         = '0;
                     sweep_color_in = dflt_ff;
                  end
                  ACT_READ: begin
                     rd_a     = req_read_addr[ADDR_W-1:0];
                     rd_ok_in = (15'(req_read_addr) < 15'(CELLS));
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            q_line_in = prod_line[DIV_SHIFT +: ADDR_W];
            q_tab_in  = prod_tab[DIV_SHIFT +: ADDR_W];
         end
         ST_EMIT: begin
            wr_addr = cursor_ff;
            unique case (op_ff)
               OP_TAB: begin
                  glyph_we  = 1'b1;
                  attr_we   = 1'b1;
                  wr_glyph  = CH_TAB;
                  wr_attr   = MARKER_COLOR;
                  cursor_in = sat_cell(tab_next);
               end
               OP_NL: begin
                  glyph_we  = 1'b1;
                  attr_we   = 1'b1;
                  wr_glyph  = CH_NL;
                  wr_attr   = MARKER_COLOR;
                  cursor_in = sat_cell(line_next);
               end
               default: begin
                  ptr_in     = cursor_ff;
                  cnt_in     = '0;
                  scan_nl_in = at_line;
                  if (!at_line && !at_tab && cursor_ff != '0) begin
                     glyph_we  = 1'b1;
                     attr_we   = 1'b1;
                     wr_addr   = cursor_ff - ADDR_W'(1);
                     cursor_in = cursor_ff - ADDR_W'(1);
                  end
               end
            endcase
         end
         ST_SCAN_RD: begin
            rd_a = ptr_ff - ADDR_W'(1);
            if (scan_go) begin
               ptr_in = ptr_ff - ADDR_W'(1);
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (scan_nl_ff && at_tab) begin
               // Newline marker not found: retry for a tab marker
               scan_nl_in = 1'b0;
               ptr_in     = cursor_ff;
               cnt_in     = '0;
            end else if (cursor_ff != '0) begin
               glyph_we  = 1'b1;
               attr_we   = 1'b1;
               wr_addr   = cursor_ff - ADDR_W'(1);
               cursor_in = cursor_ff - ADDR_W'(1);
            end
         end
         ST_SCAN_CHK: begin
            if (glyph_a_ff == scan_marker) begin
               glyph_we  = 1'b1;
               attr_we   = 1'b1;
               cursor_in = ptr_ff;
            end
         end
         ST_FOLLOW: begin
            if (follow_go) view_in = view_ff + ADDR_W'(LINE_WIDTH);
         end
         ST_CMP_RD: begin
            rd_a = ADDR_W'(start_ff + WIDE_W'(idx_ff));
            rd_b = base_ff + idx_ff;
         end
         ST_CMP_CHK: begin
            if (glyph_a_ff != glyph_b_ff) begin
               start_in = start_ff + WIDE_W'(1);
               idx_in   = '0;
            end else if (idx_ff == len_ff - ADDR_W'(1)) begin
               ptr_in = ADDR_W'(start_ff);
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_HL_WR: begin
            attr_we = 1'b1;
            wr_attr = hl_ff;
            ptr_in  = ptr_ff + ADDR_W'(1);
            if (WIDE_W'(ptr_ff) == seg_end) begin
               start_in = start_ff + WIDE_W'(len_ff);
               idx_in   = '0;
            end
         end
         ST_RS_BLANK: begin
            glyph_we = 1'b1;
            attr_we  = 1'b1;
            ptr_in   = (ptr_ff == cursor_ff) ? '0 : ptr_ff + ADDR_W'(1);
         end
         ST_RS_RD: ;
         ST_RS_CHK: begin
            if (attr_a_ff == hl_ff) attr_we = 1'b1;
            if (ptr_ff == base_ff) begin
               cursor_in = base_ff;
               mode_in   = MODE_TYPING;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_READ: begin
            if (rd_ok_ff) begin
               cell_char_in  = glyph_a_ff;
               cell_color_in = attr_a_ff;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cursor_in = cursor_ff;
               rsp_view_in   = view_ff;
               rsp_mode_in   = mode_ff;
               rsp_char_in   = cell_char_ff;
               rsp_color_in  = cell_color_ff;
            end
         end
         default: ;
      endcase
   end

   // Cell memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (glyph_we) glyph_mem[wr_addr] <= wr_glyph;
      if (attr_we) attr_mem[wr_addr] <= wr_attr;
      glyph_a_ff <= glyph_mem[rd_a];
      glyph_b_ff <= glyph_mem[rd_b];
      attr_a_ff  <= attr_mem[rd_a];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         cursor_ff      <= '0;
         view_ff        <= '0;
         mode_ff        <= MODE_TYPING;
         base_ff        <= '0;
         dflt_ff        <= RESET_DEFAULT_COLOR;
         hl_ff          <= RESET_HIGHLIGHT_COLOR;
         sweep_color_ff <= RESET_DEFAULT_COLOR;
         ptr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_ff      <= cursor_in;
         view_ff        <= view_in;
         mode_ff        <= mode_in;
         base_ff        <= base_in;
         dflt_ff        <= dflt_in;
         hl_ff          <= hl_in;
         sweep_color_ff <= sweep_color_in;
         ptr_ff         <= ptr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Work and payload registers
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      q_line_ff     <= q_line_in;
      q_tab_ff      <= q_tab_in;
      op_ff         <= op_in;
      scan_nl_ff    <= scan_nl_in;
      rd_ok_ff      <= rd_ok_in;
      cell_char_ff  <= cell_char_in;
      cell_color_ff <= cell_color_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_view_ff   <= rsp_view_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_color_ff  <= rsp_color_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_cell     = 14'(rsp_cursor_ff);
   assign rsp_view_first_cell = 14'(rsp_view_ff);
   assign rsp_console_mode    = rsp_mode_ff;
   assign rsp_cell_char       = rsp_char_ff;
   assign rsp_cell_color      = rsp_color_ff;

   // A transaction is taken only by the idle sequencer
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (state_ff == ST_IDLE))
      else $error("transaction taken outside idle");

   // A finished transaction with a free output always yields a result
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished transaction produced no result");

   // The highlight write loop stays below the pattern base
   a_hl_below_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HL_WR) |-> (ptr_ff < base_ff))
      else $error("highlight write reached the pattern");

endmodule
`default_nettype wire
